// ===== hw/rtl/guidance_packet_parser_assert.svh =====
// Assertion macros shared by the guidance packet parser RTL.
`ifndef GUIDANCE_PACKET_PARSER_ASSERT_SVH
`define GUIDANCE_PACKET_PARSER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define GPP_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("guidance_packet_parser: implication check failed");

// Next-cycle implication, disabled during reset.
`define GPP_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("guidance_packet_parser: next-cycle check failed");

`endif

// ===== hw/rtl/gpp_pkg.sv =====
// Package with types and constants for the guidance packet parser.
`timescale 1ns / 1ps

package gpp_pkg;

  localparam int ROWS = 16;
  localparam logic [15:0] ROW_MASK = 16'((32'd1 << ROWS) - 32'd1);

  localparam logic [7:0] HDR_BYTE0 = 8'h80;
  localparam logic [7:0] HDR_BYTE1 = 8'h81;

  localparam logic [7:0] CODE_HELLO = 8'd200;
  localparam logic [7:0] CODE_ADDR  = 8'd201;
  localparam logic [7:0] CODE_SPEED = 8'd254;
  localparam logic [7:0] CODE_ROWS  = 8'd229;

  localparam logic [3:0] POS_HDR0   = 4'd0;
  localparam logic [3:0] POS_HDR1   = 4'd1;
  localparam logic [3:0] POS_CODE   = 4'd3;
  localparam logic [3:0] POS_PL_LO  = 4'd5;
  localparam logic [3:0] POS_PL_HI  = 4'd6;
  localparam logic [3:0] POS_ADDR0  = 4'd7;
  localparam logic [3:0] POS_ADDR1  = 4'd8;
  localparam logic [3:0] POS_ADDR2  = 4'd9;
  localparam logic [3:0] POS_MAX    = 4'd15;

  // Last-byte positions that satisfy each minimum length.
  localparam logic [3:0] POS_MIN_ANY     = 4'd3;
  localparam logic [3:0] POS_MIN_PAYLOAD = 4'd6;
  localparam logic [3:0] POS_MIN_ADDR    = 4'd9;

  // Tenths of km/h to mph, Q12.8 after a shift by 8.
  localparam logic [11:0] SPEED_SCALE = 12'd4072;

  typedef enum logic [2:0] {
    KIND_NONE  = 3'd0,
    KIND_HELLO = 3'd1,
    KIND_ADDR  = 3'd2,
    KIND_SPEED = 3'd3,
    KIND_ROWS  = 3'd4
  } msg_kind_t;

  typedef struct packed {
    msg_kind_t   kind;
    logic [15:0] rows;
    logic [19:0] speed;
    logic [23:0] prefix;
    logic        restart;
  } result_t;

endpackage

// ===== hw/rtl/gpp_in_reg.sv =====
// Input holding register for received bytes.
`timescale 1ns / 1ps

module gpp_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       out_free,
  output logic       step,
  output logic [7:0] hold_byte,
  output logic       hold_last
);

  logic hold_valid;

  assign step     = hold_valid && (!hold_last || out_free);
  assign in_ready = !hold_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_valid <= 1'b1;
    end else if (step) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_byte <= in_byte;
      hold_last <= in_last;
    end
  end

endmodule

// ===== hw/rtl/gpp_core.sv =====
// Packet state tracking and message decode for the guidance packet parser.
`timescale 1ns / 1ps

module gpp_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  logic [7:0]      rx_byte,
  input  logic            last,
  output logic            res_load,
  output gpp_pkg::result_t res
);

  logic [3:0]  pos;
  logic        hdr;
  logic [7:0]  code;
  logic [7:0]  pl_lo;
  logic [7:0]  pl_hi;
  logic [23:0] addr;
  logic [15:0] rows;
  logic [19:0] speed;
  logic [23:0] prefix;

  logic [3:0]  pos_next;
  logic        hdr_next;
  logic [7:0]  code_next;
  logic [7:0]  pl_lo_next;
  logic [7:0]  pl_hi_next;
  logic [23:0] addr_next;
  logic [15:0] raw;
  logic [27:0] product;
  gpp_pkg::result_t res_next;

  always_comb begin
    hdr_next   = hdr;
    code_next  = code;
    pl_lo_next = pl_lo;
    pl_hi_next = pl_hi;
    addr_next  = addr;
    unique case (pos)
      gpp_pkg::POS_HDR0:  hdr_next = hdr && (rx_byte == gpp_pkg::HDR_BYTE0);
      gpp_pkg::POS_HDR1:  hdr_next = hdr && (rx_byte == gpp_pkg::HDR_BYTE1);
      gpp_pkg::POS_CODE:  code_next = rx_byte;
      gpp_pkg::POS_PL_LO: pl_lo_next = rx_byte;
      gpp_pkg::POS_PL_HI: pl_hi_next = rx_byte;
      gpp_pkg::POS_ADDR0: addr_next[7:0] = rx_byte;
      gpp_pkg::POS_ADDR1: addr_next[15:8] = rx_byte;
      gpp_pkg::POS_ADDR2: addr_next[23:16] = rx_byte;
      default: ;
    endcase
    pos_next = (pos == gpp_pkg::POS_MAX) ? pos : pos + 4'd1;
  end

  assign raw     = {pl_hi_next, pl_lo_next};
  assign product = 28'(raw) * 28'(gpp_pkg::SPEED_SCALE);

  always_comb begin
    res_next.kind    = gpp_pkg::KIND_NONE;
    res_next.rows    = rows;
    res_next.speed   = speed;
    res_next.prefix  = prefix;
    res_next.restart = 1'b0;
    if (pos >= gpp_pkg::POS_MIN_ANY && hdr_next) begin
      if (code_next == gpp_pkg::CODE_HELLO) begin
        res_next.kind = gpp_pkg::KIND_HELLO;
      end else if (code_next == gpp_pkg::CODE_ADDR && pos >= gpp_pkg::POS_MIN_ADDR) begin
        res_next.kind    = gpp_pkg::KIND_ADDR;
        res_next.prefix  = addr_next;
        res_next.restart = 1'b1;
      end else if (code_next == gpp_pkg::CODE_SPEED && pos >= gpp_pkg::POS_MIN_PAYLOAD) begin
        res_next.kind  = gpp_pkg::KIND_SPEED;
        res_next.speed = product[27:8];
      end else if (code_next == gpp_pkg::CODE_ROWS && pos >= gpp_pkg::POS_MIN_PAYLOAD) begin
        res_next.kind = gpp_pkg::KIND_ROWS;
        res_next.rows = raw & gpp_pkg::ROW_MASK;
      end
    end
  end

  assign res_load = step && last;
  assign res      = res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      hdr    <= 1'b1;
      code   <= '0;
      pl_lo  <= '0;
      pl_hi  <= '0;
      addr   <= '0;
      rows   <= '0;
      speed  <= '0;
      prefix <= '0;
    end else if (step) begin
      if (last) begin
        pos    <= '0;
        hdr    <= 1'b1;
        code   <= '0;
        pl_lo  <= '0;
        pl_hi  <= '0;
        addr   <= '0;
        rows   <= res_next.rows;
        speed  <= res_next.speed;
        prefix <= res_next.prefix;
      end else begin
        pos   <= pos_next;
        hdr   <= hdr_next;
        code  <= code_next;
        pl_lo <= pl_lo_next;
        pl_hi <= pl_hi_next;
        addr  <= addr_next;
      end
    end
  end

endmodule

// ===== hw/rtl/gpp_out_reg.sv =====
// Result register for the guidance packet parser output stream.
`timescale 1ns / 1ps

module gpp_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  gpp_pkg::result_t res_in,
  output logic             out_free,
  output logic             out_valid,
  input  logic             out_ready,
  output gpp_pkg::result_t res_out
);

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

// ===== hw/rtl/guidance_packet_parser.sv =====
// Guidance packet parser: byte stream in, one decoded message record per packet out.
// Input stream: one payload byte per transfer on s_axis_tdata, s_axis_tlast on the
//   final byte of each packet. Packets must start with 0x80 0x81; byte 3 is the code.
// Output stream: one transfer per packet, issued for its last byte only. m_axis_tuser
//   carries the message kind; m_axis_tdata carries row states, speed in mph Q12.8,
//   the stored network prefix and the restart flag.
// Throughput: one byte per cycle, sustained, including across packet boundaries, while the receiver does not stall.
// A last byte is held in the input holding register, then decoded into the result
//   register, which raises m_axis_tvalid.
// The decode is a single pass: byte capture, a 16x12 multiply for speed and the
//   length checks sit between the holding register and the result register.
// Reset (rst, synchronous): clears the packet tracker, rows, speed and prefix, and
//   empties both registers.
// Receiver stall: the result register holds its transfer; non-final bytes keep
//   flowing, and a final byte waits in the holding register until the result
//   register frees, which then backpressures s_axis_tready.
`timescale 1ns / 1ps

`include "guidance_packet_parser_assert.svh"

module guidance_packet_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [15:0] row_states, [35:16] speed_mph_q8,
                                      // [43:36] prefix_first, [51:44] prefix_second,
                                      // [59:52] prefix_third, [60] restart_request
  output logic [2:0]  m_axis_tuser    // [2:0] msg_kind
);

  logic             out_free;
  logic             step;
  logic [7:0]       hold_byte;
  logic             hold_last;
  logic             res_load;
  gpp_pkg::result_t res_core;
  gpp_pkg::result_t res_out;

  gpp_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_byte   (s_axis_tdata),
    .in_last   (s_axis_tlast),
    .out_free  (out_free),
    .step      (step),
    .hold_byte (hold_byte),
    .hold_last (hold_last)
  );

  gpp_core u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .rx_byte  (hold_byte),
    .last     (hold_last),
    .res_load (res_load),
    .res      (res_core)
  );

  gpp_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (res_load),
    .res_in    (res_core),
    .out_free  (out_free),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .res_out   (res_out)
  );

  assign m_axis_tuser = res_out.kind;
  assign m_axis_tdata = {3'b000, res_out.restart, res_out.prefix, res_out.speed,
                         res_out.rows};

  `GPP_ASSERT_IMP(a_restart_kind, clk, rst, m_axis_tvalid && m_axis_tdata[60],
    m_axis_tuser == gpp_pkg::KIND_ADDR)
  `GPP_ASSERT_IMP(a_load_needs_room, clk, rst, res_load, out_free)
  `GPP_ASSERT_NEXT(a_result_from_last, clk, rst, !res_load && !m_axis_tvalid,
    !m_axis_tvalid)

endmodule
